// ----- hdl/tgp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgp_pkg
// shared types, constants and the code-page map of the glyph placer
// ----------------------------------------------------------------------------
package tgp_pkg;

  localparam int GLYPH_SLOTS = 256;
  localparam int SLOT_BITS   = $clog2(GLYPH_SLOTS);
  localparam int COORD_BITS  = 16;
  localparam int CODE_BITS   = 8;
  localparam int COUNT_BITS  = 9;
  localparam int TARGET_BITS = 15;
  localparam int STEP_BITS   = 8;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 15;

  localparam logic [COUNT_BITS-1:0] SLOT_LIMIT = COUNT_BITS'(GLYPH_SLOTS);

  localparam logic [CODE_BITS-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [CODE_BITS-1:0] CHAR_SPACE   = 8'h20;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [CODE_BITS-1:0]  code_t;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_CHAR  = 2'd1,
    OP_WIDTH = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ATLAS_FRAMES  = 3'd0,
    REG_WIDTH_COUNT   = 3'd1,
    REG_TARGET_WIDTH  = 3'd2,
    REG_TARGET_HEIGHT = 3'd3,
    REG_LINE_STEP     = 3'd4,
    REG_SPACE_STEP    = 3'd5,
    REG_GLYPH_GAP     = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0]  atlas_frames;
    logic [COUNT_BITS-1:0]  width_count;
    logic [TARGET_BITS-1:0] target_width;
    logic [TARGET_BITS-1:0] target_height;
    logic [STEP_BITS-1:0]   line_step;
    logic [STEP_BITS-1:0]   space_step;
    logic [STEP_BITS-1:0]   glyph_gap;
  } cfg_t;

  // one item held between the input register and the cursor stage
  typedef struct packed {
    logic [1:0] operation;
    code_t      char_code;
    code_t      slot;
    coord_t     origin_x;
    coord_t     origin_y;
  } stage_item_t;

  // single-byte code page to atlas slot, zero means no glyph
  function automatic code_t map_code(input code_t c);
    code_t slot;
    slot = '0;
    if (c inside {[8'h21:8'h7F]}) begin
      slot = c - 8'h20;
    end else if (c == 8'hA8) begin
      slot = 8'd112;
    end else if (c == 8'hB8) begin
      slot = 8'd105;
    end else if (c inside {[8'hC0:8'hEF]}) begin
      slot = c - 8'h30;
    end else if (c inside {[8'hF0:8'hFF]}) begin
      slot = c - 8'h20;
    end
    return slot;
  endfunction

endpackage

// ----- hdl/tgp_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgp_in_if
// input channel of the glyph placer: valid, ready and one item
// ----------------------------------------------------------------------------
interface tgp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  char_code;
  logic [15:0] origin_x;
  logic [15:0] origin_y;
  logic [7:0]  width_slot;
  logic [7:0]  width_value;

  modport source (
    output valid, operation, char_code, origin_x, origin_y, width_slot, width_value,
    input  ready
  );
  modport sink (
    input  valid, operation, char_code, origin_x, origin_y, width_slot, width_value,
    output ready
  );
endinterface

// ----- hdl/tgp_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgp_out_if
// result channel of the glyph placer: valid, ready and one draw command
// ----------------------------------------------------------------------------
interface tgp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] draw_x;
  logic [15:0] draw_y;
  logic [7:0]  glyph_slot;

  modport source (
    output valid, draw_x, draw_y, glyph_slot,
    input  ready
  );
  modport sink (
    input  valid, draw_x, draw_y, glyph_slot,
    output ready
  );
endinterface

// ----- hdl/tgp_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgp_cfg_regs
// configuration register bank, write only
// ----------------------------------------------------------------------------
module tgp_cfg_regs import tgp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output cfg_t                     cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ATLAS_FRAMES:  cfg_nxt.atlas_frames  = cfg_wdata[COUNT_BITS-1:0];
        REG_WIDTH_COUNT:   cfg_nxt.width_count   = cfg_wdata[COUNT_BITS-1:0];
        REG_TARGET_WIDTH:  cfg_nxt.target_width  = cfg_wdata[TARGET_BITS-1:0];
        REG_TARGET_HEIGHT: cfg_nxt.target_height = cfg_wdata[TARGET_BITS-1:0];
        REG_LINE_STEP:     cfg_nxt.line_step     = cfg_wdata[STEP_BITS-1:0];
        REG_SPACE_STEP:    cfg_nxt.space_step    = cfg_wdata[STEP_BITS-1:0];
        REG_GLYPH_GAP:     cfg_nxt.glyph_gap     = cfg_wdata[STEP_BITS-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.atlas_frames  <= 9'd256;
      cfg_r.width_count   <= 9'd256;
      cfg_r.target_width  <= 15'd320;
      cfg_r.target_height <= 15'd240;
      cfg_r.line_step     <= 8'd18;
      cfg_r.space_step    <= 8'd4;
      cfg_r.glyph_gap     <= 8'd2;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hdl/tgp_width_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgp_width_mem
// glyph width table, one write port and one registered read port
// ----------------------------------------------------------------------------
module tgp_width_mem import tgp_pkg::*; (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [SLOT_BITS-1:0] wr_addr,
  input  logic [7:0]           wr_data,
  input  logic                 rd_en,
  input  logic [SLOT_BITS-1:0] rd_addr,
  output logic [7:0]           rd_data
);

  logic [7:0] mem [GLYPH_SLOTS];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data held while the stage behind is stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/tgp_place.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgp_place
// item register, cursor state and draw command output register
// ----------------------------------------------------------------------------
module tgp_place import tgp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  stage_item_t in_item,
  input  logic [7:0]  glyph_width,
  output logic        out_valid,
  input  logic        out_ready,
  output coord_t      out_draw_x,
  output coord_t      out_draw_y,
  output code_t       out_glyph_slot
);

  logic        stg_valid_r;
  logic        stg_valid_nxt;
  stage_item_t stg_item_r;

  coord_t cursor_x_r, cursor_x_nxt;
  coord_t cursor_y_r, cursor_y_nxt;
  coord_t line_start_r, line_start_nxt;

  logic   out_valid_r, out_valid_nxt;
  coord_t draw_x_r;
  coord_t draw_y_r;
  code_t  glyph_slot_r;

  logic   stg_adv;
  logic   in_accept;
  logic   emit;
  logic   slot_ok;
  logic   in_target;

  assign stg_adv   = stg_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !stg_valid_r || stg_adv;
  assign in_accept = in_valid && in_ready;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (in_accept) begin
      stg_valid_nxt = 1'b1;
    end else if (stg_adv) begin
      stg_valid_nxt = 1'b0;
    end
  end

  assign slot_ok = (stg_item_r.slot != '0)
                && ({1'b0, stg_item_r.slot} < cfg.atlas_frames)
                && ({1'b0, stg_item_r.slot} < cfg.width_count)
                && ({1'b0, stg_item_r.slot} < SLOT_LIMIT);

  // signed cursor against unsigned target
  assign in_target = ($signed({cursor_x_r[COORD_BITS-1], cursor_x_r})
                      < $signed({2'b00, cfg.target_width}))
                  && ($signed({cursor_y_r[COORD_BITS-1], cursor_y_r})
                      < $signed({2'b00, cfg.target_height}));

  always_comb begin
    cursor_x_nxt   = cursor_x_r;
    cursor_y_nxt   = cursor_y_r;
    line_start_nxt = line_start_r;
    emit           = 1'b0;
    if (stg_adv) begin
      case (op_t'(stg_item_r.operation))
        OP_BEGIN: begin
          cursor_x_nxt   = stg_item_r.origin_x;
          cursor_y_nxt   = stg_item_r.origin_y;
          line_start_nxt = stg_item_r.origin_x;
        end
        OP_CHAR: begin
          if (stg_item_r.char_code == CHAR_NEWLINE) begin
            cursor_x_nxt = line_start_r;
            cursor_y_nxt = cursor_y_r + COORD_BITS'(cfg.line_step);
          end else if (stg_item_r.char_code == CHAR_SPACE) begin
            cursor_x_nxt = cursor_x_r + COORD_BITS'(cfg.space_step);
          end else if (slot_ok) begin
            emit         = in_target;
            cursor_x_nxt = cursor_x_r + COORD_BITS'(glyph_width)
                         + COORD_BITS'(cfg.glyph_gap);
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (stg_adv) begin
      out_valid_nxt = emit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      cursor_x_r   <= '0;
      cursor_y_r   <= '0;
      line_start_r <= '0;
    end else begin
      stg_valid_r  <= stg_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      cursor_x_r   <= cursor_x_nxt;
      cursor_y_r   <= cursor_y_nxt;
      line_start_r <= line_start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      stg_item_r <= in_item;
    end
    if (emit) begin
      draw_x_r     <= cursor_x_r;
      draw_y_r     <= cursor_y_r;
      glyph_slot_r <= stg_item_r.slot;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_draw_x     = draw_x_r;
  assign out_draw_y     = draw_y_r;
  assign out_glyph_slot = glyph_slot_r;

  a_only_chars_draw: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_adv && stg_item_r.operation != OP_CHAR) |=> !out_valid_r)
    else $error("draw command from a non-character item");

  a_slot_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (glyph_slot_r != '0))
    else $error("draw command with empty slot");

  a_cursor_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_valid_r && !stg_adv) |=> ($stable(cursor_x_r) && $stable(cursor_y_r)))
    else $error("cursor moved while the item stage stalled");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !stg_valid_r |-> in_ready)
    else $error("input not ready with an empty item stage");

endmodule

// ----- hdl/text_glyph_placer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_glyph_placer_core
// lays out a byte string as glyph draw commands
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle unless the output stalls, and a draw
// command passes an item register and then the output register. An accepted
// beat lands in the item register while the glyph width table is read at the
// slot that the code-page map gives; then the cursor stage adds width and gap
// (or space step, or line step) to the cursor and fills the output register.
// The registered read port of the width table and the single cursor add set
// that rate. A stalled output holds the item register, and the input keeps
// taking beats as long as a slot is free. The width table has no reset and no
// clearing pass: an entry must be loaded before a character that uses it.
// Configuration writes are taken at any edge and belong in idle time.
// ----------------------------------------------------------------------------
module text_glyph_placer_core import tgp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  tgp_in_if.sink                   in_ch,
  tgp_out_if.source                out_ch,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  cfg_t        cfg;
  stage_item_t in_item;
  code_t       in_slot;
  logic        in_ready;
  logic        in_accept;
  logic        width_wr;
  logic [7:0]  glyph_width;

  // register bank
  tgp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // slot lookup happens on the input beat so the width is registered with the item
  assign in_slot   = map_code(in_ch.char_code);
  assign in_accept = in_ch.valid && in_ready;

  // loads to slots past the table are dropped
  assign width_wr = in_accept
                 && (in_ch.operation == OP_WIDTH)
                 && ({1'b0, in_ch.width_slot} < SLOT_LIMIT);

  // a load followed by a character on the same slot is safe: the write lands
  // at an earlier edge than the read
  tgp_width_mem u_widths (
    .clk     (clk),
    .wr_en   (width_wr),
    .wr_addr (in_ch.width_slot[SLOT_BITS-1:0]),
    .wr_data (in_ch.width_value),
    .rd_en   (in_accept),
    .rd_addr (in_slot[SLOT_BITS-1:0]),
    .rd_data (glyph_width)
  );

  always_comb begin
    in_item.operation = in_ch.operation;
    in_item.char_code = in_ch.char_code;
    in_item.slot      = in_slot;
    in_item.origin_x  = in_ch.origin_x;
    in_item.origin_y  = in_ch.origin_y;
  end

  // cursor and output stage
  tgp_place u_place (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ready),
    .in_item        (in_item),
    .glyph_width    (glyph_width),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_draw_x     (out_ch.draw_x),
    .out_draw_y     (out_ch.draw_y),
    .out_glyph_slot (out_ch.glyph_slot)
  );

  assign in_ch.ready = in_ready;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for text_glyph_placer_core: directed and random text
// streams drive the input channel under random idling and back-pressure; a
// scoreboard tracks the cursor, the width table and the registers, predicts
// each draw command and compares it field by field with the result beats
// ----------------------------------------------------------------------------
module testbench;
  import tgp_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX   = 10;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS [PHASES] = '{160, 80, 80, 160, 160, 180, 180, 280};

  // operation code the block has to ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    coord_t x;
    coord_t y;
    code_t  slot;
  } draw_t;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of registers, cursor and width table
  // --------------------------------------------------------------------------
  class glyph_draw_board;
    logic [COUNT_BITS-1:0]  frames;
    logic [COUNT_BITS-1:0]  widths_valid;
    logic [TARGET_BITS-1:0] width_lim;
    logic [TARGET_BITS-1:0] height_lim;
    logic [STEP_BITS-1:0]   line_adv;
    logic [STEP_BITS-1:0]   space_adv;
    logic [STEP_BITS-1:0]   gap_adv;
    coord_t                 pen_x;
    coord_t                 pen_y;
    coord_t                 margin_x;
    logic [7:0]             advance [GLYPH_SLOTS];
    draw_t                  pending_draws [$];
    int                     mismatches;

    function new();
      frames       = 9'd256;
      widths_valid = 9'd256;
      width_lim    = 15'd320;
      height_lim   = 15'd240;
      line_adv     = 8'd18;
      space_adv    = 8'd4;
      gap_adv      = 8'd2;
      pen_x        = '0;
      pen_y        = '0;
      margin_x     = '0;
      mismatches   = 0;
      foreach (advance[i]) advance[i] = '0;
    endfunction

    function void set_reg(cfg_reg_t idx, int value);
      case (idx)
        REG_ATLAS_FRAMES:  frames       = value[COUNT_BITS-1:0];
        REG_WIDTH_COUNT:   widths_valid = value[COUNT_BITS-1:0];
        REG_TARGET_WIDTH:  width_lim    = value[TARGET_BITS-1:0];
        REG_TARGET_HEIGHT: height_lim   = value[TARGET_BITS-1:0];
        REG_LINE_STEP:     line_adv     = value[STEP_BITS-1:0];
        REG_SPACE_STEP:    space_adv    = value[STEP_BITS-1:0];
        REG_GLYPH_GAP:     gap_adv      = value[STEP_BITS-1:0];
        default: ;
      endcase
    endfunction

    // code page to atlas slot, zero for bytes without a glyph
    function code_t slot_of(code_t c);
      if (c >= 8'h21 && c <= 8'h7F) return c - 8'h20;
      if (c == 8'hA8) return 8'd112;
      if (c == 8'hB8) return 8'd105;
      if (c >= 8'hC0 && c <= 8'hEF) return c - 8'h30;
      if (c >= 8'hF0) return c - 8'h20;
      return 8'd0;
    endfunction

    function bit slot_drawable(code_t slot);
      return slot != 8'd0 && {1'b0, slot} < frames && {1'b0, slot} < widths_valid;
    endfunction

    function void note_beat(logic [1:0] op, code_t code, coord_t ox, coord_t oy,
                            code_t ws, code_t wv);
      code_t slot;
      case (op)
        OP_BEGIN: begin
          pen_x    = ox;
          pen_y    = oy;
          margin_x = ox;
        end
        OP_WIDTH: advance[ws] = wv;
        OP_CHAR: begin
          if (code == CHAR_NEWLINE) begin
            pen_x = margin_x;
            pen_y = pen_y + coord_t'(line_adv);
          end else if (code == CHAR_SPACE) begin
            pen_x = pen_x + coord_t'(space_adv);
          end else begin
            slot = slot_of(code);
            if (slot_drawable(slot)) begin
              if ($signed(pen_x) < $signed({1'b0, width_lim}) &&
                  $signed(pen_y) < $signed({1'b0, height_lim})) begin
                pending_draws.push_back('{pen_x, pen_y, slot});
              end
              pen_x = pen_x + coord_t'(advance[slot]) + coord_t'(gap_adv);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_draw(coord_t x, coord_t y, code_t slot);
      draw_t got;
      draw_t want;
      got = '{x, y, slot};
      if (pending_draws.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("mismatch: unexpected draw x=%0d y=%0d slot=%0d",
                   $signed(x), $signed(y), slot);
        return;
      end
      want = pending_draws.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("mismatch: expected x=%0d y=%0d slot=%0d, got x=%0d y=%0d slot=%0d",
                   $signed(want.x), $signed(want.y), want.slot,
                   $signed(got.x), $signed(got.y), got.slot);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, block under test
  // --------------------------------------------------------------------------
  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  tgp_in_if  in_ch ();
  tgp_out_if out_ch ();

  text_glyph_placer_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  glyph_draw_board board = new();

  // width entries loaded so far, so that no character reads an unwritten one
  bit width_known [GLYPH_SLOTS];
  bit hold_req;
  bit quiet;
  int cycles = 0;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // both channels sampled at the rising edge; inputs only move at the falling one
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        board.note_beat(in_ch.operation, in_ch.char_code, in_ch.origin_x,
                        in_ch.origin_y, in_ch.width_slot, in_ch.width_value);
      if (out_ch.valid && out_ch.ready)
        board.check_draw(out_ch.draw_x, out_ch.draw_y, out_ch.glyph_slot);
    end
  end

  // --------------------------------------------------------------------------
  // result side: short random stalls, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        // long hold-off so the block fills up and stalls its input
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // input side tasks; each starts and ends at a falling edge
  // --------------------------------------------------------------------------
  task automatic send_item(logic [1:0] op, code_t code, coord_t ox, coord_t oy,
                           code_t ws, code_t wv);
    in_ch.operation   = op;
    in_ch.char_code   = code;
    in_ch.origin_x    = ox;
    in_ch.origin_y    = oy;
    in_ch.width_slot  = ws;
    in_ch.width_value = wv;
    in_ch.valid       = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic pause_sender(int n);
    in_ch.valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic send_begin(coord_t ox, coord_t oy);
    send_item(OP_BEGIN, code_t'($urandom), ox, oy, code_t'($urandom), code_t'($urandom));
  endtask

  task automatic send_width(code_t ws, code_t wv);
    width_known[ws] = 1'b1;
    send_item(OP_WIDTH, code_t'($urandom), coord_t'($urandom), coord_t'($urandom), ws, wv);
  endtask

  // a drawable glyph whose width entry is still unknown gets it loaded first
  task automatic send_char(code_t code);
    code_t slot;
    slot = board.slot_of(code);
    if (board.slot_drawable(slot) && !width_known[slot])
      send_width(slot, code_t'($urandom_range(0, 15)));
    send_item(OP_CHAR, code, coord_t'($urandom), coord_t'($urandom),
              code_t'($urandom), code_t'($urandom));
  endtask

  task automatic write_reg(cfg_reg_t idx, int value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value[CFG_DATA_BITS-1:0];
    board.set_reg(idx, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // wait for the last draw, then let skipped characters leave the pipeline
  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (board.pending_draws.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apply_setup(int fc, int wc, int tw, int th, int ls, int ss, int gg);
    write_reg(REG_ATLAS_FRAMES, fc);
    write_reg(REG_WIDTH_COUNT, wc);
    write_reg(REG_TARGET_WIDTH, tw);
    write_reg(REG_TARGET_HEIGHT, th);
    write_reg(REG_LINE_STEP, ls);
    write_reg(REG_SPACE_STEP, ss);
    write_reg(REG_GLYPH_GAP, gg);
  endtask

  function automatic int pick_target();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 600);
  endfunction

  task automatic setup_phase(int p);
    case (p)
      0: apply_setup(256, 256, 32767, 32767, 0, 0, 0);
      1: apply_setup(0, 256, 320, 240, 255, 255, 255);     // no frames, nothing drawn
      2: apply_setup(256, 0, 32767, 32767, 18, 4, 2);      // no widths, nothing drawn
      3: apply_setup(100, 200, 0, 0, 18, 4, 2);            // only negative cursors draw
      4: apply_setup(200, 100, 640, 480, 255, 255, 255);
      7: apply_setup(256, 256, 320, 240, 18, 4, 2);
      default: apply_setup($urandom_range(1, 256), $urandom_range(1, 256), pick_target(),
                           pick_target(), $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255));
    endcase
  endtask

  // mostly text lines with origins near the target, some noise in between
  task automatic random_item();
    int    pick;
    int    sub;
    coord_t ox;
    coord_t oy;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      if ($urandom_range(0, 99) < 65) begin
        ox = coord_t'($urandom_range(0, 460) - 60);
        oy = coord_t'($urandom_range(0, 360) - 60);
      end else begin
        ox = coord_t'($urandom);
        oy = coord_t'($urandom);
      end
      send_begin(ox, oy);
    end else if (pick < 20) begin
      send_width(code_t'($urandom),
                 code_t'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 12)));
    end else if (pick < 23) begin
      send_item(OP_UNUSED, code_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                code_t'($urandom), code_t'($urandom));
    end else begin
      sub = $urandom_range(0, 99);
      if (sub < 12)      send_char(CHAR_NEWLINE);
      else if (sub < 24) send_char(CHAR_SPACE);
      else if (sub < 65) send_char(code_t'($urandom_range(8'h21, 8'h7F)));
      else if (sub < 80) send_char(code_t'($urandom_range(8'hA8, 8'hFF)));
      else               send_char(code_t'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    in_ch.valid       = 1'b0;
    in_ch.operation   = '0;
    in_ch.char_code   = '0;
    in_ch.origin_x    = '0;
    in_ch.origin_y    = '0;
    in_ch.width_slot  = '0;
    in_ch.width_value = '0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    hold_req          = 1'b0;
    quiet             = 1'b0;
    rst_n             = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // directed part under the reset register values
    send_begin(16'd0, 16'd0);
    send_width(8'd0, 8'd0);                 // slot zero is never drawn
    send_width(8'd255, 8'd255);
    send_char(8'h21);                       // lowest printable byte
    send_char(8'hFF);                       // top of the high range
    send_char(8'hA8);
    send_char(8'hB8);
    send_char(8'hC0);
    send_char(8'hF0);
    send_char(CHAR_SPACE);
    send_char(CHAR_NEWLINE);
    send_char(8'h00);                       // unmapped low byte
    send_char(8'h80);                       // unmapped high byte
    send_item(OP_UNUSED, 8'h41, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    send_begin(16'h8000, 16'h7FFF);         // below the target row, advance only
    send_char(8'h41);
    send_begin(16'h7FFF, 16'h8000);         // right of the target width
    send_char(8'h5F);
    send_begin(16'hFFF0, 16'hFFF0);         // negative cursor draws
    send_char(8'h7F);

    // random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      if (p == PHASES - 1) quiet = 1'b1;     // last phase runs without idling
      setup_phase(p);
      for (int i = 0; i < PHASE_ITEMS[p]; i++) begin
        if (p == 0 && i == 30) hold_req = 1'b1;
        if (p == 4 && i == 80) begin
          // sender waits for every outstanding draw
          in_ch.valid = 1'b0;
          while (board.pending_draws.size() != 0) @(negedge clk);
        end
        random_item();
        if (!quiet && (i / 40) % 2 == 0 && $urandom_range(0, 4) == 0)
          pause_sender($urandom_range(1, 8));
      end
    end

    in_ch.valid = 1'b0;
    while (board.pending_draws.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending_draws.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- text_glyph_placer_core.f -----
hdl/tgp_pkg.sv
hdl/tgp_in_if.sv
hdl/tgp_out_if.sv
hdl/tgp_cfg_regs.sv
hdl/tgp_width_mem.sv
hdl/tgp_place.sv
hdl/text_glyph_placer_core.sv
tb/testbench.sv
